// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

    // Longest key that is stored; later key bytes are dropped.
    localparam int KEY_MAX = 256;

    // Controller states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_PR_RD_J,
        ST_PR_WR_I,
        ST_PR_WR_J
    } t_state;

    // Datapath operations, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_FILL,
        OP_KEY_WR,
        OP_KS_RD_N,
        OP_KS_RD_J,
        OP_KS_WR_N,
        OP_KS_WR_J,
        OP_PR_RD_I,
        OP_PR_RD_J,
        OP_PR_WR_I,
        OP_PR_WR_J
    } t_dp_op;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        t_dp_op op;
        logic   ks_start;
        logic   ks_done;
        logic   out_load;
    } t_dp_cmd;

    // Status bundle from the datapath to the controller.
    typedef struct packed {
        logic n_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/rc4_ctrl.sv =====
module rc4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    input  logic              i_key_last,
    input  rc4_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output rc4_pkg::t_dp_cmd  o_cmd
);
    import rc4_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.ks_start = 1'b0;
        o_cmd.ks_done  = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.op = OP_FILL;
                if (i_stat.n_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_command) begin
                        o_cmd.op = OP_PR_RD_I;
                        n_state  = ST_PR_RD_J;
                    end else begin
                        o_cmd.op       = OP_KEY_WR;
                        o_cmd.ks_start = i_key_last;
                        if (i_key_last) begin
                            n_state = ST_FILL;
                        end
                    end
                end
            end
            ST_FILL: begin
                o_cmd.op = OP_FILL;
                if (i_stat.n_last) begin
                    n_state = ST_KS_RD_N;
                end
            end
            ST_KS_RD_N: begin
                o_cmd.op = OP_KS_RD_N;
                n_state  = ST_KS_RD_J;
            end
            ST_KS_RD_J: begin
                o_cmd.op = OP_KS_RD_J;
                n_state  = ST_KS_WR_N;
            end
            ST_KS_WR_N: begin
                o_cmd.op = OP_KS_WR_N;
                n_state  = ST_KS_WR_J;
            end
            ST_KS_WR_J: begin
                o_cmd.op = OP_KS_WR_J;
                if (i_stat.n_last) begin
                    o_cmd.ks_done = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    n_state = ST_KS_RD_N;
                end
            end
            ST_PR_RD_J: begin
                o_cmd.op = OP_PR_RD_J;
                n_state  = ST_PR_WR_I;
            end
            ST_PR_WR_I: begin
                o_cmd.op = OP_PR_WR_I;
                n_state  = ST_PR_WR_J;
            end
            ST_PR_WR_J: begin
                // Hold here until the output register can take the result.
                o_cmd.op = OP_PR_WR_J;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/rc4_datapath.sv =====
module rc4_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc4_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]        i_data_byte,
    input  logic              i_ready,
    output rc4_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_key_ready
);
    import rc4_pkg::*;

    // S-box and key store memories.
    logic [7:0] r_sbox [256];
    logic [7:0] r_key  [256];
    logic [7:0] r_sbox_rd;
    logic [7:0] r_key_rd;

    // Indices, counters and flags.
    logic [7:0] r_n;
    logic [7:0] r_k;
    logic [7:0] r_i;
    logic [7:0] r_j;
    logic [8:0] r_key_len;
    logic       r_keyed;

    // Working registers for a data request or a key schedule step.
    logic [7:0] r_si;
    logic [7:0] r_sj;
    logic [7:0] r_t;
    logic [7:0] r_byte;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_key_ready;

    // S-box and key store port controls.
    logic       sb_we;
    logic [7:0] sb_waddr;
    logic [7:0] sb_wdata;
    logic       sb_re;
    logic [7:0] sb_raddr;
    logic       key_we;
    logic       key_re;

    logic [7:0] i_next;
    logic [7:0] j_ks;
    logic [7:0] j_pr;
    logic [7:0] t_sum;
    logic [7:0] ks_byte;
    logic       k_wrap;

    assign i_next = r_i + 8'd1;
    assign j_ks   = r_j + r_sbox_rd + r_key_rd;
    assign j_pr   = r_j + r_sbox_rd;
    assign t_sum  = r_si + r_sbox_rd;
    assign k_wrap = ({1'b0, r_k} + 9'd1) == r_key_len;

    // Keystream byte: the read of S[t] saw the S-box before the j write,
    // and before the i write when t equals i, so forward the swapped values.
    always_comb begin
        if (r_t == r_j) begin
            ks_byte = r_si;
        end else if (r_t == r_i) begin
            ks_byte = r_sj;
        end else begin
            ks_byte = r_sbox_rd;
        end
    end

    // Memory port selection.
    always_comb begin
        sb_we    = 1'b0;
        sb_waddr = r_n;
        sb_wdata = r_n;
        sb_re    = 1'b0;
        sb_raddr = r_n;
        key_we   = 1'b0;
        key_re   = 1'b0;
        unique case (i_cmd.op)
            OP_FILL: begin
                sb_we = 1'b1;
            end
            OP_KEY_WR: begin
                key_we = r_key_len < 9'(KEY_MAX);
            end
            OP_KS_RD_N: begin
                sb_re  = 1'b1;
                key_re = 1'b1;
            end
            OP_KS_RD_J: begin
                sb_re    = 1'b1;
                sb_raddr = j_ks;
            end
            OP_KS_WR_N: begin
                sb_we    = 1'b1;
                sb_wdata = r_sbox_rd;
            end
            OP_KS_WR_J: begin
                sb_we    = 1'b1;
                sb_waddr = r_j;
                sb_wdata = r_si;
            end
            OP_PR_RD_I: begin
                sb_re    = 1'b1;
                sb_raddr = i_next;
            end
            OP_PR_RD_J: begin
                sb_re    = 1'b1;
                sb_raddr = j_pr;
            end
            OP_PR_WR_I: begin
                sb_we    = 1'b1;
                sb_waddr = r_i;
                sb_wdata = r_sbox_rd;
                sb_re    = 1'b1;
                sb_raddr = t_sum;
            end
            OP_PR_WR_J: begin
                sb_we    = 1'b1;
                sb_waddr = r_j;
                sb_wdata = r_si;
            end
            default: begin
                sb_we = 1'b0;
            end
        endcase
    end

    // S-box memory with registered read.
    always_ff @(posedge i_clk) begin
        if (sb_we) begin
            r_sbox[sb_waddr] <= sb_wdata;
        end
        if (sb_re) begin
            r_sbox_rd <= r_sbox[sb_raddr];
        end
    end

    // Key store memory with registered read.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[r_key_len[7:0]] <= i_data_byte;
        end
        if (key_re) begin
            r_key_rd <= r_key[r_k];
        end
    end

    // Indices, key length and keyed flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= 8'd0;
            r_k       <= 8'd0;
            r_i       <= 8'd0;
            r_j       <= 8'd0;
            r_key_len <= 9'd0;
            r_keyed   <= 1'b0;
        end else begin
            if (i_cmd.op == OP_FILL) begin
                r_n <= r_n + 8'd1;
            end
            if (key_we) begin
                r_key_len <= r_key_len + 9'd1;
            end
            if (i_cmd.ks_start) begin
                r_j <= 8'd0;
                r_k <= 8'd0;
            end
            if (i_cmd.op == OP_KS_RD_J) begin
                r_j <= j_ks;
            end
            if (i_cmd.op == OP_KS_WR_J) begin
                r_n <= r_n + 8'd1;
                r_k <= k_wrap ? 8'd0 : r_k + 8'd1;
            end
            if (i_cmd.op == OP_PR_RD_I) begin
                r_i <= i_next;
            end
            if (i_cmd.op == OP_PR_RD_J) begin
                r_j <= j_pr;
            end
            if (i_cmd.ks_done) begin
                r_i       <= 8'd0;
                r_j       <= 8'd0;
                r_key_len <= 9'd0;
                r_keyed   <= 1'b1;
            end
        end
    end

    // Working registers for a data request or a key schedule step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PR_RD_I) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.op == OP_KS_RD_J || i_cmd.op == OP_PR_RD_J) begin
            r_si <= r_sbox_rd;
        end
        if (i_cmd.op == OP_PR_WR_I) begin
            r_sj <= r_sbox_rd;
            r_t  <= t_sum;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte      <= r_byte ^ ks_byte;
            r_out_key_ready <= r_keyed;
        end
    end

    assign o_stat.n_last   = r_n == 8'hFF;
    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_key_ready     = r_out_key_ready;

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------
// request  | i_valid / o_ready  | i_command, i_data_byte, i_key_last
// result   | o_valid / i_ready  | o_out_byte, o_key_ready
//
// Key bytes are taken back to back. A data byte holds off further requests
// while it reads S[i], reads S[j] and reads S[t] with swap, as the S-box
// memory has a single read port. The last key byte starts an identity fill
// and the key schedule (read S[n] and K[k], read S[j], write S[n] and S[j]).
// After reset an identity fill of the S-box runs before o_ready rises.
// A result waits in the output register; a further data byte stalls in
// its last cycle only while that register is still full.
module rc4_stream_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    input  logic       i_key_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_key_ready
);
    import rc4_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_command  (i_command),
        .i_key_last (i_key_last),
        .i_stat     (dp_stat),
        .o_ready    (o_ready),
        .o_cmd      (dp_cmd)
    );

    // S-box, key store and output register.
    rc4_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_data_byte (i_data_byte),
        .i_ready     (i_ready),
        .o_stat      (dp_stat),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_key_ready (o_key_ready)
    );

    // A new result appears only right after the controller loads one.
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(dp_cmd.out_load))
        else $error("result appeared without a load");

    // An accepted data request keeps the block busy in the next cycle.
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_command) |=> !o_ready)
        else $error("request taken during a data byte");

    // The last key byte starts the S-box fill at once, ahead of the key schedule.
    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_command && i_key_last) |=> !o_ready)
        else $error("request taken during key scheduling");

endmodule
